[rtl/assert_macros.svh]
// assertion macros included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rstn, a, c)
`define ASSERT_NEXT(label, clk, rstn, a, c)
`endif
`endif

[rtl/mlvs_pkg.sv]
// shared types and constants of the masked line variance block
`default_nettype none
package mlvs_pkg;
    localparam int DEPTH_W = 16;
    localparam int CNT_W = 10;
    localparam int SUM_W = 25;
    localparam int SQ_W = 41;
    localparam int FVS_W = 48;
    localparam int RUN_W = 64;
    localparam int RFC_W = 32;
    localparam int MEAN_W = 24;
    localparam int VAR_W = 38;
    localparam int FRAC_W = 8;
    localparam int NUM_W = 64;
    localparam int DEN_W = 32;
    localparam int MAX_LINE_PIXELS = 512;
    localparam int MAX_LINES = 512;
    localparam int LINE_CAP = (MAX_LINE_PIXELS < 1023) ? MAX_LINE_PIXELS : 1023;
    localparam int FRAME_CAP = (MAX_LINES < 1023) ? MAX_LINES : 1023;
    localparam logic [DEPTH_W-1:0] VALID_HIGH_RST = 16'd1000;
    localparam logic REG_VALID_LOW = 1'b0;
    localparam logic REG_VALID_HIGH = 1'b1;

    typedef enum logic [1:0] {SEL_MEAN, SEL_VAR, SEL_FMV, SEL_RMV} div_sel_t;

    typedef struct packed {
        logic     acc;
        logic     mul;
        logic     div_start;
        div_sel_t sel;
        logic     frame_upd;
        logic     run_upd;
        logic     load;
        logic     frame;
    } cmd_t;

    typedef struct packed {
        logic n_nz;
        logic fvl_nz;
        logic run_nz;
        logic div_done;
        logic div_busy;
        logic out_free;
    } sts_t;
endpackage
`default_nettype wire

[rtl/mlvs_div.sv]
// restoring divider, one quotient bit a cycle, rounds half up
`default_nettype none
module mlvs_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [mlvs_pkg::NUM_W-1:0] num,
    input  wire logic [mlvs_pkg::DEN_W-1:0] den,
    output logic                            busy,
    output logic                            done,
    output logic [mlvs_pkg::NUM_W:0]        quo
);
    import mlvs_pkg::*;

    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [5:0]       cnt_reg;
    logic             busy_reg, done_reg;
    logic [DEN_W:0]   rem_s;
    logic             ge;
    logic             rnd;

    assign rem_s = {rem_reg, num_reg[NUM_W-1]};
    assign ge = rem_s >= {1'b0, den_reg};

    always_comb begin
        num_next = {num_reg[NUM_W-2:0], ge};
        rem_next = ge ? DEN_W'(rem_s - {1'b0, den_reg}) : rem_s[DEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                num_reg  <= num;
                den_reg  <= den;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                num_reg <= num_next;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rnd = {rem_reg, 1'b0} >= {1'b0, den_reg};
    assign quo = {1'b0, num_reg} + {{NUM_W{1'b0}}, rnd};
    assign busy = busy_reg;
    assign done = done_reg;
endmodule
`default_nettype wire

[rtl/mlvs_datapath.sv]
// accumulators, products, divider and result registers
`default_nettype none
module mlvs_datapath (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire mlvs_pkg::cmd_t               cmd,
    output mlvs_pkg::sts_t                    sts,
    input  wire logic [mlvs_pkg::DEPTH_W-1:0] depth,
    input  wire logic [mlvs_pkg::DEPTH_W-1:0] valid_low,
    input  wire logic [mlvs_pkg::DEPTH_W-1:0] valid_high,
    input  wire logic                         out_ready,
    output logic                              out_valid,
    output logic [mlvs_pkg::MEAN_W-1:0]       line_mean,
    output logic [mlvs_pkg::VAR_W-1:0]        line_variance,
    output logic [mlvs_pkg::CNT_W-1:0]        valid_count,
    output logic                              line_has_valid,
    output logic                              frame_done,
    output logic                              frame_has_valid,
    output logic [mlvs_pkg::VAR_W-1:0]        frame_mean_variance,
    output logic [mlvs_pkg::VAR_W-1:0]        run_mean_variance
);
    import mlvs_pkg::*;

    logic [SUM_W-1:0]   sum_reg;
    logic [SQ_W-1:0]    sq_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [FVS_W-1:0]   fvs_reg;
    logic [CNT_W-1:0]   fvl_reg;
    logic [RUN_W-1:0]   run_reg;
    logic [RFC_W-1:0]   rfc_reg;
    logic [CNT_W+SQ_W-1:0]  a_reg;
    logic [2*SUM_W-1:0]     b_reg;
    logic [2*CNT_W-1:0]     nn_reg;
    logic [MEAN_W-1:0]  mean_reg;
    logic [VAR_W-1:0]   var_reg, fmv_reg, rmv_reg;
    logic               ov_reg;

    logic               pix_ok;
    logic [SUM_W:0]     sum_add;
    logic [SQ_W:0]      sq_add;
    logic [2*DEPTH_W-1:0] dsq;
    logic [FVS_W:0]     fvs_add;
    logic [RUN_W:0]     run_add;
    logic [NUM_W-1:0]   dnum;
    logic [DEN_W-1:0]   dden;
    logic               dbusy, ddone;
    logic [NUM_W:0]     dq;
    logic [CNT_W+SQ_W-1:0] diff;

    assign pix_ok = (depth > valid_low) && (depth < valid_high) && (cnt_reg < CNT_W'(LINE_CAP));
    assign dsq = (2*DEPTH_W)'(depth) * (2*DEPTH_W)'(depth);
    assign sum_add = {1'b0, sum_reg} + (SUM_W+1)'(depth);
    assign sq_add = {1'b0, sq_reg} + (SQ_W+1)'(dsq);
    assign fvs_add = {1'b0, fvs_reg} + (FVS_W+1)'(var_reg);
    assign run_add = {1'b0, run_reg} + (RUN_W+1)'(fmv_reg);
    assign diff = a_reg - (CNT_W+SQ_W)'(b_reg);

    always_comb begin
        case (cmd.sel)
            SEL_MEAN: begin
                dnum = NUM_W'({sum_reg, {FRAC_W{1'b0}}});
                dden = DEN_W'(cnt_reg);
            end
            SEL_VAR: begin
                dnum = (a_reg > (CNT_W+SQ_W)'(b_reg)) ? NUM_W'({diff, {FRAC_W{1'b0}}}) : '0;
                dden = DEN_W'(nn_reg);
            end
            SEL_FMV: begin
                dnum = NUM_W'(fvs_reg);
                dden = DEN_W'(fvl_reg);
            end
            default: begin
                dnum = run_reg;
                dden = rfc_reg;
            end
        endcase
    end

    mlvs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (dnum),
        .den     (dden),
        .busy    (dbusy),
        .done    (ddone),
        .quo     (dq)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            sq_reg  <= '0;
            cnt_reg <= '0;
            fvs_reg <= '0;
            fvl_reg <= '0;
            run_reg <= '0;
            rfc_reg <= '0;
            ov_reg  <= 1'b0;
        end else begin
            if (cmd.load) begin
                ov_reg <= 1'b1;
            end else if (out_ready) begin
                ov_reg <= 1'b0;
            end
            if (cmd.acc && pix_ok) begin
                sum_reg <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
                sq_reg  <= sq_add[SQ_W] ? {SQ_W{1'b1}} : sq_add[SQ_W-1:0];
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.mul) begin
                a_reg    <= (CNT_W+SQ_W)'(cnt_reg) * (CNT_W+SQ_W)'(sq_reg);
                b_reg    <= (2*SUM_W)'(sum_reg) * (2*SUM_W)'(sum_reg);
                nn_reg   <= (2*CNT_W)'(cnt_reg) * (2*CNT_W)'(cnt_reg);
                mean_reg <= '0;
                var_reg  <= '0;
                fmv_reg  <= '0;
                rmv_reg  <= '0;
            end
            if (ddone) begin
                case (cmd.sel)
                    SEL_MEAN: mean_reg <= (dq > (NUM_W+1)'({MEAN_W{1'b1}})) ?
                                          {MEAN_W{1'b1}} : dq[MEAN_W-1:0];
                    SEL_VAR:  var_reg <= (dq > (NUM_W+1)'({VAR_W{1'b1}})) ?
                                         {VAR_W{1'b1}} : dq[VAR_W-1:0];
                    SEL_FMV:  fmv_reg <= (dq > (NUM_W+1)'({VAR_W{1'b1}})) ?
                                         {VAR_W{1'b1}} : dq[VAR_W-1:0];
                    default:  rmv_reg <= (dq > (NUM_W+1)'({VAR_W{1'b1}})) ?
                                         {VAR_W{1'b1}} : dq[VAR_W-1:0];
                endcase
            end
            if (cmd.frame_upd && (cnt_reg != '0) && (fvl_reg < CNT_W'(FRAME_CAP))) begin
                fvs_reg <= fvs_add[FVS_W] ? {FVS_W{1'b1}} : fvs_add[FVS_W-1:0];
                fvl_reg <= fvl_reg + CNT_W'(1);
            end
            if (cmd.run_upd && (fvl_reg != '0) && (rfc_reg != {RFC_W{1'b1}})
                && !run_add[RUN_W]) begin
                run_reg <= run_add[RUN_W-1:0];
                rfc_reg <= rfc_reg + RFC_W'(1);
            end
            if (cmd.load) begin
                line_mean           <= mean_reg;
                line_variance       <= var_reg;
                valid_count         <= cnt_reg;
                line_has_valid      <= cnt_reg != '0;
                frame_done          <= cmd.frame;
                frame_has_valid     <= cmd.frame && (fvl_reg != '0);
                frame_mean_variance <= fmv_reg;
                run_mean_variance   <= rmv_reg;
                sum_reg <= '0;
                sq_reg  <= '0;
                cnt_reg <= '0;
                if (cmd.frame) begin
                    fvs_reg <= '0;
                    fvl_reg <= '0;
                end
            end
        end
    end

    assign out_valid = ov_reg;
    assign sts.n_nz = cnt_reg != '0;
    assign sts.fvl_nz = fvl_reg != '0;
    assign sts.run_nz = rfc_reg != '0;
    assign sts.div_done = ddone;
    assign sts.div_busy = dbusy;
    assign sts.out_free = !ov_reg || out_ready;
endmodule
`default_nettype wire

[rtl/mlvs_ctrl.sv]
// sequencer for line close, frame close and result load
`default_nettype none
module mlvs_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    input  wire logic           line_end,
    input  wire logic           frame_end,
    output logic                in_ready,
    input  wire mlvs_pkg::sts_t sts,
    output mlvs_pkg::cmd_t      cmd
);
    import mlvs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL, ST_DSTART, ST_DWAIT, ST_FRAME, ST_FCHK, ST_RUN, ST_RCHK, ST_LOAD
    } state_t;

    state_t   state_reg;
    div_sel_t sel_reg;
    logic     frame_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sel_reg   <= SEL_MEAN;
            frame_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_valid && (line_end || frame_end)) begin
                        frame_reg <= frame_end;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    sel_reg   <= SEL_MEAN;
                    state_reg <= sts.n_nz ? ST_DSTART : ST_FRAME;
                end
                ST_DSTART: state_reg <= ST_DWAIT;
                ST_DWAIT: begin
                    if (sts.div_done) begin
                        unique case (sel_reg)
                            SEL_MEAN: begin
                                sel_reg   <= SEL_VAR;
                                state_reg <= ST_DSTART;
                            end
                            SEL_VAR: state_reg <= ST_FRAME;
                            SEL_FMV: state_reg <= ST_RUN;
                            default: state_reg <= ST_LOAD;
                        endcase
                    end
                end
                ST_FRAME: state_reg <= ST_FCHK;
                ST_FCHK: begin
                    if (!frame_reg) begin
                        state_reg <= ST_LOAD;
                    end else if (sts.fvl_nz) begin
                        sel_reg   <= SEL_FMV;
                        state_reg <= ST_DSTART;
                    end else begin
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: state_reg <= ST_RCHK;
                ST_RCHK: begin
                    if (sts.run_nz) begin
                        sel_reg   <= SEL_RMV;
                        state_reg <= ST_DSTART;
                    end else begin
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    if (sts.out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_ready = state_reg == ST_IDLE;
    assign cmd.acc = in_valid && (state_reg == ST_IDLE);
    assign cmd.mul = state_reg == ST_MUL;
    assign cmd.div_start = state_reg == ST_DSTART;
    assign cmd.sel = sel_reg;
    assign cmd.frame_upd = state_reg == ST_FRAME;
    assign cmd.run_upd = state_reg == ST_RUN;
    assign cmd.load = (state_reg == ST_LOAD) && sts.out_free;
    assign cmd.frame = frame_reg;
endmodule
`default_nettype wire

[rtl/masked_line_variance_stats.sv]
// top level: masked per-line mean and variance with frame and run statistics
// Depth pixels stream in one word a cycle while a line is open; a pixel counts
// when valid_low < depth < valid_high and fewer than LINE_CAP pixels of the
// line have counted. The word carrying line_end (tuser) or frame_end (tlast)
// closes the line: the block then stops taking words while a sequencer works
// out the mean and variance through one shared bit-serial divider, which
// loads its operands, works out 64 quotient bits and then raises done. The
// input is held off through products, two divisions, frame update and load
// on a line with valid pixels and through products, frame update and load
// on an empty line; a frame close adds divisions for the frame and run mean
// variance when those have data. The load cycle stretches while the previous
// result word is still waiting. Plain pixels take one cycle each. The result
// word waits in an output register while the next line streams in. Means and
// variances are unsigned with 8 fraction bits.
`default_nettype none
`include "assert_macros.svh"
module masked_line_variance_stats (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [15:0]  s_tdata,   // depth
    input  wire logic         s_tuser,   // line_end
    input  wire logic         s_tlast,   // frame_end
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // line_mean, line_variance, valid_count, line_has_valid, frame_has_valid,
    // frame_mean_variance, run_mean_variance, two zero bits
    output logic [151:0]      m_tdata,
    output logic              m_tlast    // frame_done
);
    import mlvs_pkg::*;

    logic [DEPTH_W-1:0] valid_low_reg, valid_high_reg;
    cmd_t cmd;
    sts_t sts;
    logic [MEAN_W-1:0] line_mean;
    logic [VAR_W-1:0]  line_variance, frame_mean_variance, run_mean_variance;
    logic [CNT_W-1:0]  valid_count;
    logic line_has_valid, frame_has_valid;

    // apb register file, writes land in the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_low_reg  <= '0;
            valid_high_reg <= VALID_HIGH_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_VALID_LOW:  valid_low_reg  <= pwdata[DEPTH_W-1:0];
                REG_VALID_HIGH: valid_high_reg <= pwdata[DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_VALID_HIGH) ? 32'(valid_high_reg) : 32'(valid_low_reg);
    assign pready = 1'b1;

    // sequencer
    mlvs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .line_end  (s_tuser),
        .frame_end (s_tlast),
        .in_ready  (s_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // accumulators, divider and output register
    mlvs_datapath u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .sts                 (sts),
        .depth               (s_tdata),
        .valid_low           (valid_low_reg),
        .valid_high          (valid_high_reg),
        .out_ready           (m_tready),
        .out_valid           (m_tvalid),
        .line_mean           (line_mean),
        .line_variance       (line_variance),
        .valid_count         (valid_count),
        .line_has_valid      (line_has_valid),
        .frame_done          (m_tlast),
        .frame_has_valid     (frame_has_valid),
        .frame_mean_variance (frame_mean_variance),
        .run_mean_variance   (run_mean_variance)
    );

    // result word packing, first field lowest
    assign m_tdata = {2'b00, run_mean_variance, frame_mean_variance, frame_has_valid,
                      line_has_valid, valid_count, line_variance, line_mean};

    // no pixel is taken while the divider runs
    `ASSERT_IMPLIES(a_no_accept_busy, aclk, aresetn, s_tready, !sts.div_busy)
    // a fresh result only follows a cycle with the input held off
    `ASSERT_IMPLIES(a_load_stalls_input, aclk, aresetn, $rose(m_tvalid), $past(!s_tready))
    // a load command always leaves a valid result behind
    `ASSERT_NEXT(a_load_sets_valid, aclk, aresetn, cmd.load, m_tvalid)
endmodule
`default_nettype wire

[tb/masked_line_variance_stats_tb.sv]
// testbench for masked_line_variance_stats: stream stimulus, line and frame statistics checks
`timescale 1ns / 100ps
`default_nettype none
module masked_line_variance_stats_tb;
    import mlvs_pkg::*;

    localparam int          CLK_PERIOD = 8;
    localparam int          CYCLE_LIMIT = 3000000;
    // idle cycles after the last result before a register write or the end
    localparam int          SETTLE_CYCLES = 400;
    localparam logic [2:0]  ADDR_VALID_LOW = 3'd0;
    localparam logic [2:0]  ADDR_VALID_HIGH = 3'd4;
    localparam logic [63:0] SUM_SAT = (64'd1 << SUM_W) - 1;
    localparam logic [63:0] SQ_SAT = (64'd1 << SQ_W) - 1;
    localparam logic [63:0] FVS_SAT = (64'd1 << FVS_W) - 1;
    localparam logic [63:0] VAR_SAT = (64'd1 << VAR_W) - 1;
    localparam logic [63:0] MEAN_SAT = (64'd1 << MEAN_W) - 1;

    typedef struct {
        logic [MEAN_W-1:0] line_mean;
        logic [VAR_W-1:0]  line_variance;
        logic [CNT_W-1:0]  valid_count;
        logic              line_has_valid;
        logic              frame_done;
        logic              frame_has_valid;
        logic [VAR_W-1:0]  frame_mean_variance;
        logic [VAR_W-1:0]  run_mean_variance;
    } line_stats_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [15:0]  s_tdata = '0;  // depth
    logic         s_tuser = 1'b0; // line_end
    logic         s_tlast = 1'b0; // frame_end
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // line_mean, line_variance, valid_count, line_has_valid, frame_has_valid,
    // frame_mean_variance, run_mean_variance, two zero bits
    logic [151:0] m_tdata;
    logic         m_tlast;       // frame_done

    masked_line_variance_stats i_dut (.*);

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // predictor copy of the registers and accumulators
    logic [15:0] bound_low = 16'd0;
    logic [15:0] bound_high = VALID_HIGH_RST;
    logic [63:0] pix_sum = '0, pix_sq_sum = '0, pix_count = '0;
    logic [63:0] frm_var_sum = '0, frm_lines = '0;
    logic [63:0] run_var_sum = '0, run_frames = '0;

    line_stats_t expected_stats[$];
    int unsigned words_in = 0, results_seen = 0, frames_seen = 0, errors = 0;
    int unsigned cycles = 0;
    int unsigned send_idle_pct = 0, recv_idle_pct = 0;
    int unsigned hold_off_cycles = 0;

    function automatic logic [63:0] round_div(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q, r;
        q = num / den;
        r = num % den;
        if (r >= den - r) q++;
        return q;
    endfunction

    function automatic logic [63:0] sat(input logic [63:0] v, input logic [63:0] lim);
        return (v > lim) ? lim : v;
    endfunction

    // advance the predictor by one depth word; returns 1 when a result is due
    function automatic bit predict_line_stats(input logic [15:0] depth, input logic line_end,
                                              input logic frame_end, output line_stats_t r);
        logic [63:0] d, a, b, num, n, fmv;
        d = {48'd0, depth};
        r = '{default: '0};
        if (depth > bound_low && depth < bound_high && pix_count < LINE_CAP) begin
            pix_sum = sat(pix_sum + d, SUM_SAT);
            pix_sq_sum = sat(pix_sq_sum + d * d, SQ_SAT);
            pix_count++;
        end
        if (!line_end && !frame_end) return 1'b0;
        n = pix_count;
        if (n != 0) begin
            a = n * pix_sq_sum;
            b = pix_sum * pix_sum;
            num = (a > b) ? (a - b) << 8 : 64'd0;
            r.line_mean = MEAN_W'(sat(round_div(pix_sum << 8, n), MEAN_SAT));
            r.line_variance = VAR_W'(sat(round_div(num, n * n), VAR_SAT));
            r.line_has_valid = 1'b1;
            // only the first FRAME_CAP valid lines enter the frame mean
            if (frm_lines < FRAME_CAP) begin
                frm_var_sum = sat(frm_var_sum + 64'(r.line_variance), FVS_SAT);
                frm_lines++;
            end
        end
        r.valid_count = n[CNT_W-1:0];
        pix_sum = '0;
        pix_sq_sum = '0;
        pix_count = '0;
        if (frame_end) begin
            r.frame_done = 1'b1;
            if (frm_lines != 0) begin
                fmv = sat(round_div(frm_var_sum, frm_lines), VAR_SAT);
                r.frame_has_valid = 1'b1;
                r.frame_mean_variance = fmv[VAR_W-1:0];
                // the run stops growing once its count or sum would overflow
                if (run_frames < 64'hFFFF_FFFF && run_var_sum <= ~64'd0 - fmv) begin
                    run_var_sum += fmv;
                    run_frames++;
                end
            end
            if (run_frames != 0)
                r.run_mean_variance = VAR_W'(sat(round_div(run_var_sum, run_frames), VAR_SAT));
            frm_var_sum = '0;
            frm_lines = '0;
        end
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    // monitor: predicts on every accepted depth word, checks every result word
    always @(posedge aclk) begin
        line_stats_t r, e;
        if (aresetn && s_tvalid && s_tready) begin
            if (predict_line_stats(s_tdata, s_tuser, s_tlast, r))
                expected_stats.insert(expected_stats.size(), r);
            words_in++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_stats.size() == 0) begin
                $error("result word with no expected line statistics");
                errors++;
            end else begin
                e = expected_stats.pop_front();
                if (e.frame_done) frames_seen++;
                check_field("line_mean", 64'(e.line_mean), 64'(m_tdata[23:0]));
                check_field("line_variance", 64'(e.line_variance), 64'(m_tdata[61:24]));
                check_field("valid_count", 64'(e.valid_count), 64'(m_tdata[71:62]));
                check_field("line_has_valid", 64'(e.line_has_valid), 64'(m_tdata[72]));
                check_field("frame_done", 64'(e.frame_done), 64'(m_tlast));
                check_field("frame_has_valid", 64'(e.frame_has_valid), 64'(m_tdata[73]));
                check_field("frame_mean_variance", 64'(e.frame_mean_variance),
                            64'(m_tdata[111:74]));
                check_field("run_mean_variance", 64'(e.run_mean_variance),
                            64'(m_tdata[149:112]));
                check_field("padding", 64'd0, 64'(m_tdata[151:150]));
            end
        end
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(negedge aclk) begin
        if (hold_off_cycles != 0) begin
            m_tready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // offer one depth word and wait until the block takes it
    task automatic send_depth(input logic [15:0] depth, input logic line_end,
                              input logic frame_end);
        int unsigned seen;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata <= 16'($urandom);
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= depth;
        s_tuser <= line_end;
        s_tlast <= frame_end;
        seen = words_in;
        wait (words_in != seen);
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // wait until every expected result is back and the block has gone quiet
    task automatic drain();
        stop_sending();
        while (expected_stats.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // register write: setup then access, upper data bits random (ignored by the block)
    task automatic write_bounds(input logic [15:0] low_v, input logic [15:0] high_v);
        logic [2:0]  addr[2];
        logic [15:0] val[2];
        addr = '{ADDR_VALID_LOW, ADDR_VALID_HIGH};
        val = '{low_v, high_v};
        drain();
        for (int i = 0; i < 2; i++) begin
            @(negedge aclk);
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= addr[i];
            pwdata <= {16'($urandom), val[i]};
            @(negedge aclk);
            penable <= 1'b1;
            @(negedge aclk);
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
        end
        bound_low = low_v;
        bound_high = high_v;
    endtask

    // depth inside the window or near its bounds most of the time, any value otherwise
    function automatic logic [15:0] pick_depth();
        case ($urandom_range(5))
            0:       return 16'($urandom);
            1:       return bound_low + 16'($urandom_range(2)) - 16'd1;
            2:       return bound_high + 16'($urandom_range(2)) - 16'd1;
            default: return 16'($urandom_range(bound_low, bound_high));
        endcase
    endfunction

    // one frame of random lines; the last line may close with frame_end alone
    task automatic send_frame(input int unsigned lines, input int unsigned max_len);
        int unsigned len;
        bit          bare_end;
        bare_end = ($urandom_range(3) == 0);
        for (int unsigned l = 0; l < lines; l++) begin
            len = $urandom_range(max_len, 1);
            for (int unsigned p = 0; p < len; p++) begin
                if (p == len - 1 && l == lines - 1)
                    send_depth(pick_depth(), !bare_end, 1'b1);
                else if (p == len - 1)
                    send_depth(pick_depth(), 1'b1, 1'b0);
                else
                    send_depth(pick_depth(), 1'b0, 1'b0);
            end
        end
    endtask

    // reset bounds: edges of the valid window, empty lines, bare frame end
    task automatic test_directed();
        send_depth(16'd0, 1'b1, 1'b1);      // frame with nothing valid, empty run
        send_depth(16'd0, 1'b0, 1'b0);      // low bound itself is invalid
        send_depth(16'd1, 1'b0, 1'b0);
        send_depth(16'd999, 1'b0, 1'b0);
        send_depth(16'd1000, 1'b0, 1'b0);   // high bound itself is invalid
        send_depth(16'd65535, 1'b1, 1'b0);
        send_depth(16'd500, 1'b1, 1'b0);    // single pixel line
        send_depth(16'd2000, 1'b1, 1'b0);   // empty line
        send_depth(16'd7, 1'b0, 1'b0);
        send_depth(16'd993, 1'b0, 1'b1);    // frame end closes the line too
        send_depth(16'd40000, 1'b1, 1'b0);
        send_depth(16'd0, 1'b0, 1'b1);      // frame with no valid line, run kept
        send_depth(16'd999, 1'b0, 1'b0);
        send_depth(16'd999, 1'b1, 1'b1);    // zero variance
        drain();
    endtask

    // widest window, then inverted and closed windows
    task automatic test_bounds();
        write_bounds(16'd0, 16'd65535);
        send_depth(16'd65534, 1'b0, 1'b0);
        send_depth(16'd1, 1'b0, 1'b0);
        send_depth(16'd65535, 1'b0, 1'b0);
        send_depth(16'd32768, 1'b1, 1'b1);
        write_bounds(16'd65535, 16'd0);
        send_depth(16'd12345, 1'b0, 1'b0);
        send_depth(16'd65535, 1'b1, 1'b1);
        write_bounds(16'd300, 16'd300);
        send_depth(16'd300, 1'b0, 1'b0);
        send_depth(16'd301, 1'b1, 1'b1);
        write_bounds(16'd65534, 16'd65535);
        send_depth(16'd65535, 1'b1, 1'b1);
    endtask

    // a line longer than the pixel cap, large values near the top of the range
    task automatic test_long_line();
        write_bounds(16'd0, 16'd65535);
        for (int i = 0; i < LINE_CAP + 40; i++)
            send_depth(16'($urandom_range(65534, 60000)), 1'b0, 1'b0);
        send_depth(16'd65534, 1'b1, 1'b0);
        send_depth(16'd3, 1'b1, 1'b1);
    endtask

    // more valid lines in one frame than the frame statistics take
    task automatic test_many_lines();
        write_bounds(16'd10, 16'd20000);
        for (int i = 0; i < FRAME_CAP + 8; i++)
            send_depth(16'($urandom_range(19999, 11)), 1'b1, (i == FRAME_CAP + 7));
    endtask

    // receiver holds off for a long stretch while words keep coming
    task automatic test_hold_off();
        write_bounds(16'd100, 16'd60000);
        @(negedge aclk);
        hold_off_cycles <= 3000;
        for (int f = 0; f < 6; f++) send_frame($urandom_range(4, 1), 16);
        drain();
    endtask

    // random frames under one idle setting, bounds changed now and then
    task automatic test_random(input int unsigned snd_pct, input int unsigned rcv_pct,
                               input int unsigned n_words);
        int unsigned start;
        logic [15:0] lo, hi;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        start = words_in;
        while (words_in - start < n_words) begin
            if ($urandom_range(7) == 0) begin
                lo = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(2000));
                hi = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom_range(65535, 1000));
                write_bounds(lo, hi);
            end
            send_frame($urandom_range(5, 1), ($urandom_range(9) == 0) ? 60 : 20);
        end
        drain();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 21;
        recv_idle_pct = 49;
        test_directed();
        test_bounds();
        test_long_line();
        test_many_lines();
        test_hold_off();
        write_bounds(16'd0, VALID_HIGH_RST);
        test_random(21, 49, 100);
        test_random(49, 21, 100);
        test_random(0, 0, 100);
        $display("covered %0d depth words, %0d line results, %0d frame closes",
                 words_in, results_seen, frames_seen);
        $display("bounds swept from closed and inverted windows to the full 16-bit range");
        if (errors == 0 && expected_stats.size() == 0) begin
            $display("No mismatches found");
        end else begin
            if (expected_stats.size() != 0)
                $error("%0d expected results never arrived", expected_stats.size());
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
`default_nettype wire
